### hdl/stepseq_pkg.sv
// ----------------------------------------------------------------------------
// stepseq_pkg
// shared types, constants and coil tables of the stepper phase sequencer
// ----------------------------------------------------------------------------
package stepseq_pkg;

    // widths of the transaction fields
    localparam int OP_W       = 2;
    localparam int MODEL_W    = 2;
    localparam int FIELD_W    = 32;
    localparam int PERIOD_W   = 8;
    localparam int COILS_W    = 4;
    localparam int PHASE_W    = 4;

    // default width of the step and delay counters
    localparam int COUNT_WIDTH_DEF = 32;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_TICK      = 2'd0,
        OP_START     = 2'd1,
        OP_SET_DELAY = 2'd2,
        OP_UNUSED    = 2'd3
    } t_op;

    // drive models
    typedef enum logic [MODEL_W-1:0] {
        MODEL_BIPOLAR = 2'd0,
        MODEL_WAVE    = 2'd1,
        MODEL_TWO     = 2'd2,
        MODEL_HALF    = 2'd3
    } t_model;

    typedef logic [COILS_W-1:0] t_coils;
    typedef logic [PHASE_W-1:0] t_phase;

    // phase marks loaded by a start move, and the last phase of each wrap
    localparam t_phase PHASE_BEFORE_CW  = 4'd15;
    localparam t_phase PHASE_BEFORE_CCW = 4'd4;
    localparam t_phase PHASE_LAST_FULL  = 4'd3;
    localparam t_phase PHASE_LAST_HALF  = 4'd7;

    localparam t_coils TBL_BIPOLAR [4] = '{4'hA, 4'h6, 4'h5, 4'h9};
    localparam t_coils TBL_WAVE    [4] = '{4'h1, 4'h2, 4'h4, 4'h8};
    localparam t_coils TBL_TWO     [4] = '{4'h9, 4'h3, 4'h6, 4'hC};
    localparam t_coils TBL_HALF    [8] = '{4'h9, 4'h1, 4'h3, 4'h2,
                                           4'h6, 4'h4, 4'hC, 4'h8};

    // coil pattern for a phase, keeps the old pattern when the phase has no entry
    function automatic t_coils coil_lookup(input t_model model, input t_phase phase,
                                           input t_coils old_coils);
        t_coils res;
        res = old_coils;
        case (model)
            MODEL_HALF: begin
                if (phase < 4'd8) res = TBL_HALF[phase[2:0]];
            end
            MODEL_BIPOLAR: begin
                if (phase < 4'd4) res = TBL_BIPOLAR[phase[1:0]];
            end
            MODEL_WAVE: begin
                if (phase < 4'd4) res = TBL_WAVE[phase[1:0]];
            end
            default: begin
                if (phase < 4'd4) res = TBL_TWO[phase[1:0]];
            end
        endcase
        return res;
    endfunction

endpackage

### hdl/stepper_phase_sequencer.sv
// ----------------------------------------------------------------------------
// stepper_phase_sequencer
// phase sequencer and coil driver for a four-coil stepper motor
// ----------------------------------------------------------------------------
// Each input transaction is a tick of one millisecond, a start move or a set
// delay, and every transaction returns exactly one result with the coil
// pattern, the steps left and the delay ticks left after the update. The
// block takes one transaction per clock cycle while o_in_stall is low; its
// result is registered. All state updates are combinational between the
// motor state registers and the result register. Behind the result register
// sits a one-entry skid register, so input keeps flowing for one more
// transaction while a result waits; o_in_stall rises only when both output
// entries are full. drive_model is written through the configuration
// channel, which is always ready and should only be written while idle.
// ----------------------------------------------------------------------------
module stepper_phase_sequencer #(
    parameter int COUNT_WIDTH = stepseq_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    // configuration channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [stepseq_pkg::MODEL_W-1:0]     i_cfg_drive_model,

    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [stepseq_pkg::OP_W-1:0]        i_operation,
    input  logic [stepseq_pkg::FIELD_W-1:0]     i_step_count,
    input  logic [stepseq_pkg::PERIOD_W-1:0]    i_ticks_per_step,
    input  logic                                i_clockwise,
    input  logic [stepseq_pkg::FIELD_W-1:0]     i_delay_ticks,

    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [stepseq_pkg::COILS_W-1:0]     o_coils,
    output logic [stepseq_pkg::FIELD_W-1:0]     o_steps_left,
    output logic [stepseq_pkg::FIELD_W-1:0]     o_delay_left
);
    import stepseq_pkg::*;

    typedef logic [COUNT_WIDTH-1:0] t_count;

    // one result entry
    typedef struct packed {
        t_coils coils;
        t_count steps;
        t_count delay;
    } t_result;

    // configuration
    t_model r_model;

    // motor state
    t_phase                r_phase,     n_phase;
    logic [PERIOD_W-1:0]   r_tick_cd,   n_tick_cd;
    logic [PERIOD_W-1:0]   r_reload,    n_reload;
    logic                  r_dir,       n_dir;
    t_count                r_steps,     n_steps;
    t_count                r_delay,     n_delay;
    t_coils                r_coils,     n_coils;

    // output buffer: result register and skid register
    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    t_result n_result;

    logic in_accept;
    logic out_take;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_skid_valid;
    assign in_accept   = i_in_valid && !r_skid_valid;
    assign out_take    = r_out_valid && !i_out_stall;

    // ------------------------------------------------------------------
    // next motor state for the transaction at the input
    // ------------------------------------------------------------------
    always_comb begin
        t_phase              last;
        t_phase              adv_phase;
        logic [PERIOD_W-1:0] dec_cd;
        logic [PERIOD_W-1:0] period;

        n_phase  = r_phase;
        n_tick_cd = r_tick_cd;
        n_reload = r_reload;
        n_dir    = r_dir;
        n_steps  = r_steps;
        n_delay  = r_delay;
        n_coils  = r_coils;

        last = (r_model == MODEL_HALF) ? PHASE_LAST_HALF : PHASE_LAST_FULL;

        // one position forward or back, wrapping by the drive model
        if (r_dir) begin
            adv_phase = (r_phase >= last) ? '0 : r_phase + 4'd1;
        end else begin
            adv_phase = (r_phase == '0 || r_phase == PHASE_BEFORE_CW) ? last
                                                                      : r_phase - 4'd1;
        end

        dec_cd = r_tick_cd - 8'd1;
        period = (i_ticks_per_step == '0) ? 8'd1 : i_ticks_per_step;

        case (t_op'(i_operation))
            OP_TICK: begin
                if (r_delay != '0) n_delay = r_delay - t_count'(1);
                n_tick_cd = dec_cd;
                // divider expiry
                if (dec_cd == '0) begin
                    n_tick_cd = r_reload;
                    if (r_steps != '0) begin
                        n_phase = adv_phase;
                        n_steps = r_steps - t_count'(1);
                        n_coils = coil_lookup(r_model, adv_phase, r_coils);
                    end
                    // coils off once the move is done
                    if (r_steps <= t_count'(1)) n_coils = '0;
                end
            end
            OP_START: begin
                n_reload  = period;
                n_tick_cd = period;
                n_dir     = i_clockwise;
                n_steps   = i_step_count[COUNT_WIDTH-1:0];
                n_phase   = i_clockwise ? PHASE_BEFORE_CW : PHASE_BEFORE_CCW;
            end
            OP_SET_DELAY: begin
                n_delay = i_delay_ticks[COUNT_WIDTH-1:0];
            end
            default: begin
            end
        endcase

        n_result.coils = n_coils;
        n_result.steps = n_steps;
        n_result.delay = n_delay;
    end

    // ------------------------------------------------------------------
    // configuration register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_model <= MODEL_BIPOLAR;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_model <= t_model'(i_cfg_drive_model);
        end
    end

    // ------------------------------------------------------------------
    // motor state
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= '0;
            r_tick_cd <= 8'd1;
            r_reload  <= 8'd1;
            r_dir     <= 1'b0;
            r_steps   <= '0;
            r_delay   <= '0;
            r_coils   <= '0;
        end else if (in_accept) begin
            r_phase   <= n_phase;
            r_tick_cd <= n_tick_cd;
            r_reload  <= n_reload;
            r_dir     <= n_dir;
            r_steps   <= n_steps;
            r_delay   <= n_delay;
            r_coils   <= n_coils;
        end
    end

    // ------------------------------------------------------------------
    // output buffer control
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                // no accept while the skid entry is full
                if (out_take) r_skid_valid <= 1'b0;
            end else if (in_accept) begin
                if (r_out_valid && i_out_stall) begin
                    r_skid_valid <= 1'b1;
                end else begin
                    r_out_valid <= 1'b1;
                end
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output buffer payload
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) r_out <= r_skid;
        end else if (in_accept) begin
            if (r_out_valid && i_out_stall) begin
                r_skid <= n_result;
            end else begin
                r_out <= n_result;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_coils      = r_out.coils;
    assign o_steps_left = FIELD_W'(r_out.steps);
    assign o_delay_left = FIELD_W'(r_out.delay);

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry full while result register empty");

    a_divider_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tick_cd != '0) && (r_reload != '0))
        else $error("step divider or reload reached zero");

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase < 4'd8) || (r_phase == PHASE_BEFORE_CW))
        else $error("phase outside the reachable set");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_out_stall) |=> !r_skid_valid)
        else $error("skid entry not moved into result register");

endmodule

### tb/stepseq_checker.sv
// ----------------------------------------------------------------------------
// stepseq_checker
// watches the stepper sequencer channels, predicts every result and compares
// ----------------------------------------------------------------------------
module stepseq_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_ready,
    input  logic [stepseq_pkg::MODEL_W-1:0]     i_cfg_drive_model,
    input  logic                                i_in_valid,
    input  logic                                i_in_stall,
    input  logic [stepseq_pkg::OP_W-1:0]        i_operation,
    input  logic [stepseq_pkg::FIELD_W-1:0]     i_step_count,
    input  logic [stepseq_pkg::PERIOD_W-1:0]    i_ticks_per_step,
    input  logic                                i_clockwise,
    input  logic [stepseq_pkg::FIELD_W-1:0]     i_delay_ticks,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  logic [stepseq_pkg::COILS_W-1:0]     i_coils,
    input  logic [stepseq_pkg::FIELD_W-1:0]     i_steps_left,
    input  logic [stepseq_pkg::FIELD_W-1:0]     i_delay_left,
    output int                                  o_mismatch_cnt,
    output int                                  o_pending_cnt
);
    timeunit 1ns;
    timeprecision 1ps;
    import stepseq_pkg::*;

    // coil sequences, entry i in nibble i
    localparam logic [31:0] SEQ_HALF    = 32'h8C46_2319;
    localparam logic [15:0] SEQ_BIPOLAR = 16'h956A;
    localparam logic [15:0] SEQ_WAVE    = 16'h8421;
    localparam logic [15:0] SEQ_TWO     = 16'hC639;

    typedef struct packed {
        t_coils              coils;
        logic [FIELD_W-1:0]  steps_left;
        logic [FIELD_W-1:0]  delay_left;
    } t_motor_status;

    t_motor_status expected_status_q[$];

    // predicted motor state
    t_model              drive_model;
    t_phase              phase;
    logic [PERIOD_W-1:0] tick_countdown;
    logic [PERIOD_W-1:0] tick_reload;
    logic                direction;
    logic [FIELD_W-1:0]  remaining_steps;
    logic [FIELD_W-1:0]  delay_counter;
    t_coils              coil_pattern;

    function automatic t_coils pattern_at(t_model m, t_phase p, t_coils held);
        t_coils res;
        res = held;
        if (m == MODEL_HALF) begin
            if (p < 4'd8) res = SEQ_HALF[p[2:0]*4 +: 4];
        end else if (p < 4'd4) begin
            case (m)
                MODEL_BIPOLAR: res = SEQ_BIPOLAR[p[1:0]*4 +: 4];
                MODEL_WAVE:    res = SEQ_WAVE[p[1:0]*4 +: 4];
                default:       res = SEQ_TWO[p[1:0]*4 +: 4];
            endcase
        end
        return res;
    endfunction

    task automatic apply_motor_item(t_op op, logic [FIELD_W-1:0] cnt,
                                    logic [PERIOD_W-1:0] tps, logic cw,
                                    logic [FIELD_W-1:0] dly);
        t_phase last;
        last = (drive_model == MODEL_HALF) ? PHASE_LAST_HALF : PHASE_LAST_FULL;
        case (op)
            OP_TICK: begin
                if (delay_counter != '0) delay_counter = delay_counter - 32'd1;
                tick_countdown = tick_countdown - 8'd1;
                if (tick_countdown == '0) begin
                    tick_countdown = tick_reload;
                    if (remaining_steps != '0) begin
                        if (direction)
                            phase = (phase >= last) ? 4'd0 : phase + 4'd1;
                        else if (phase == 4'd0 || phase == PHASE_BEFORE_CW)
                            phase = last;
                        else
                            phase = phase - 4'd1;
                        coil_pattern = pattern_at(drive_model, phase, coil_pattern);
                        remaining_steps = remaining_steps - 32'd1;
                    end
                    if (remaining_steps == '0) coil_pattern = '0;
                end
            end
            OP_START: begin
                tick_reload     = (tps == '0) ? 8'd1 : tps;
                tick_countdown  = tick_reload;
                direction       = cw;
                remaining_steps = cnt;
                phase           = cw ? PHASE_BEFORE_CW : PHASE_BEFORE_CCW;
            end
            OP_SET_DELAY: begin
                delay_counter = dly;
            end
            default: begin
            end
        endcase
        expected_status_q.push_back('{coil_pattern, remaining_steps, delay_counter});
    endtask

    initial begin
        o_mismatch_cnt = 0;
        o_pending_cnt  = 0;
    end

    always @(posedge i_clk) begin
        t_motor_status exp_s;
        if (!i_rst_n) begin
            drive_model     = MODEL_BIPOLAR;
            phase           = '0;
            tick_countdown  = 8'd1;
            tick_reload     = 8'd1;
            direction       = 1'b0;
            remaining_steps = '0;
            delay_counter   = '0;
            coil_pattern    = '0;
            expected_status_q.delete();
        end else begin
            // results first, the item taken at this edge cannot be out yet
            if (i_out_valid && !i_out_stall) begin
                if (expected_status_q.size() == 0) begin
                    $error("result transaction with no expectation waiting");
                    o_mismatch_cnt++;
                end else begin
                    exp_s = expected_status_q.pop_front();
                    if (i_coils !== exp_s.coils) begin
                        $error("coils mismatch: expected %h actual %h",
                               exp_s.coils, i_coils);
                        o_mismatch_cnt++;
                    end
                    if (i_steps_left !== exp_s.steps_left) begin
                        $error("steps_left mismatch: expected %h actual %h",
                               exp_s.steps_left, i_steps_left);
                        o_mismatch_cnt++;
                    end
                    if (i_delay_left !== exp_s.delay_left) begin
                        $error("delay_left mismatch: expected %h actual %h",
                               exp_s.delay_left, i_delay_left);
                        o_mismatch_cnt++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) drive_model = t_model'(i_cfg_drive_model);
            if (i_in_valid && !i_in_stall)
                apply_motor_item(t_op'(i_operation), i_step_count, i_ticks_per_step,
                                 i_clockwise, i_delay_ticks);
        end
        o_pending_cnt = expected_status_q.size();
    end

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the stepper phase sequencer
// ----------------------------------------------------------------------------
// A directed run walks the delay countdown to zero, a clamped zero period,
// moves in both directions, the phase wrap of full and half step, the unused
// operation and a drive model change in the middle of a move. Then about 800
// random transactions follow in twelve segments, with the drive model
// rewritten between segments while moves are still running. The checker
// beside the block predicts and compares every result transaction.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import stepseq_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 40;
    localparam int SEGMENTS    = 12;
    localparam int SEG_ITEMS   = 67;
    localparam int DRAIN_WAIT  = 8;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [MODEL_W-1:0]  i_cfg_drive_model;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [OP_W-1:0]     i_operation;
    logic [FIELD_W-1:0]  i_step_count;
    logic [PERIOD_W-1:0] i_ticks_per_step;
    logic                i_clockwise;
    logic [FIELD_W-1:0]  i_delay_ticks;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [COILS_W-1:0]  o_coils;
    logic [FIELD_W-1:0]  o_steps_left;
    logic [FIELD_W-1:0]  o_delay_left;

    int mismatch_cnt;
    int pending_cnt;
    int cycle_cnt = 0;

    // idle chances in percent per cycle, changed between phases of the run
    int  tx_idle_pct = 0;
    int  rx_idle_pct = 0;
    // request for one long receiver hold-off
    bit  hold_req = 1'b0;

    stepper_phase_sequencer u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_drive_model (i_cfg_drive_model),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_operation       (i_operation),
        .i_step_count      (i_step_count),
        .i_ticks_per_step  (i_ticks_per_step),
        .i_clockwise       (i_clockwise),
        .i_delay_ticks     (i_delay_ticks),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_coils           (o_coils),
        .o_steps_left      (o_steps_left),
        .o_delay_left      (o_delay_left)
    );

    stepseq_checker u_chk (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_drive_model (i_cfg_drive_model),
        .i_in_valid        (i_in_valid),
        .i_in_stall        (o_in_stall),
        .i_operation       (i_operation),
        .i_step_count      (i_step_count),
        .i_ticks_per_step  (i_ticks_per_step),
        .i_clockwise       (i_clockwise),
        .i_delay_ticks     (i_delay_ticks),
        .i_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .i_coils           (o_coils),
        .i_steps_left      (o_steps_left),
        .i_delay_left      (o_delay_left),
        .o_mismatch_cnt    (mismatch_cnt),
        .o_pending_cnt     (pending_cnt)
    );

    // 8 ns clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // watchdog, far above the slowest correct run
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side: random stall, or one long hold-off counted here
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_out_stall <= ($urandom_range(99) < rx_idle_pct);
            end
        end
    end

    // offer one transaction after a random idle gap, return once it is taken
    task automatic send_item(t_op op, logic [FIELD_W-1:0] cnt,
                             logic [PERIOD_W-1:0] tps, logic cw,
                             logic [FIELD_W-1:0] dly);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_operation      <= op;
        i_step_count     <= cnt;
        i_ticks_per_step <= tps;
        i_clockwise      <= cw;
        i_delay_ticks    <= dly;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // shorthand for a tick, the unused fields carry noise
    task automatic send_tick();
        send_item(OP_TICK, $urandom, 8'($urandom), 1'($urandom), $urandom);
    endtask

    // stop offering and wait until every result is back, plus a margin
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_cnt != 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // drive model write, only with the block idle
    task automatic write_drive_model(t_model m);
        wait_drained();
        i_cfg_valid       <= 1'b1;
        i_cfg_drive_model <= m;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // random transaction: mostly ticks, short moves with small periods so
    // that steps, wraps and coil clearing come often, plus full-range noise
    task automatic send_random_item();
        int                  pick;
        int                  sel;
        t_op                 op;
        logic [FIELD_W-1:0]  cnt;
        logic [PERIOD_W-1:0] tps;
        logic [FIELD_W-1:0]  dly;
        pick = $urandom_range(99);
        cnt  = $urandom;
        tps  = 8'($urandom);
        dly  = $urandom;
        if (pick < 3) begin
            op = OP_UNUSED;
        end else if (pick < 12) begin
            op = OP_SET_DELAY;
            if ($urandom_range(1)) dly = $urandom_range(20);
        end else if (pick < 24) begin
            op  = OP_START;
            sel = $urandom_range(9);
            case (sel)
                0:       cnt = '0;
                1:       cnt = $urandom;
                2:       cnt = '1;
                default: cnt = $urandom_range(1, 12);
            endcase
            sel = $urandom_range(19);
            case (sel)
                0:       tps = '0;
                1:       tps = 8'($urandom);
                default: tps = 8'($urandom_range(1, 3));
            endcase
        end else begin
            op = OP_TICK;
        end
        send_item(op, cnt, tps, 1'($urandom), dly);
    endtask

    initial begin
        int seg;
        int n;

        // every input known from time zero
        i_rst_n           <= 1'b0;
        i_cfg_valid       <= 1'b0;
        i_cfg_drive_model <= MODEL_BIPOLAR;
        i_in_valid        <= 1'b0;
        i_operation       <= OP_TICK;
        i_step_count      <= '0;
        i_ticks_per_step  <= '0;
        i_clockwise       <= 1'b0;
        i_delay_ticks     <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed part ----
        write_drive_model(MODEL_BIPOLAR);
        // unused operation with every payload bit set, state just reported
        send_item(OP_UNUSED, '1, '1, 1'b1, '1);
        // delay countdown from its top, then down to zero where it stops
        send_item(OP_SET_DELAY, '0, '0, 1'b0, '1);
        send_tick();
        send_item(OP_SET_DELAY, '0, '0, 1'b0, 32'd1);
        send_tick();
        send_tick();
        // clockwise move with a zero period taken as one, coils clear at the end
        send_item(OP_START, 32'd3, 8'd0, 1'b1, '0);
        repeat (3) send_tick();
        // counter-clockwise move with period two, first step lands on phase 3
        send_item(OP_START, 32'd2, 8'd2, 1'b0, '0);
        repeat (4) send_tick();

        // half step counter-clockwise through the wrap from 0 to 7
        write_drive_model(MODEL_HALF);
        send_item(OP_START, '1, 8'd1, 1'b0, '0);
        repeat (5) send_tick();
        // phase now beyond the full-step table: coils held until it comes back
        write_drive_model(MODEL_TWO);
        repeat (4) send_tick();

        // ---- random part ----
        for (seg = 0; seg < SEGMENTS; seg++) begin
            // idling phases: receiver busy then sender busy, then none at all
            if (seg < 4) begin
                tx_idle_pct = 31;
                rx_idle_pct = 49;
            end else if (seg < 8) begin
                tx_idle_pct = 49;
                rx_idle_pct = 31;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            // models cycle so that each one, the extremes too, is seen often,
            // and moves still running cross a model change
            if (seg > 0) write_drive_model(t_model'(seg % 4));
            // long receiver hold-off while the sender keeps offering
            if (seg == 8) hold_req = 1'b1;
            for (n = 0; n < SEG_ITEMS; n++) send_random_item();
        end

        wait_drained();
        if (mismatch_cnt == 0 && pending_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
